// File: rtl/core/elevator_floor_controller_assert.svh
// assertion macros for the elevator floor controller
`ifndef ELEVATOR_FLOOR_CONTROLLER_ASSERT_SVH
`define ELEVATOR_FLOOR_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every clock edge out of reset
`define EFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elevator floor controller: same-cycle check failed");
// next-cycle implication
`define EFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elevator floor controller: next-cycle check failed");
`else
`define EFC_ASSERT_IMP(label, ante, cons)
`define EFC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/core/efc_pkg.sv
// types, codes and helpers shared by the elevator floor controller files
`default_nettype none

package efc_pkg;

  // field widths
  localparam int KEY_W   = 4;
  localparam int DIST_W  = 16;
  localparam int MODE_W  = 3;
  localparam int FLOOR_W = 7;
  localparam int CNT_W   = 2;

  // entry buffer depth
  localparam logic [CNT_W-1:0] ENTRY_DIGITS = 2'd2;

  // reset value of the obstruction threshold
  localparam logic [DIST_W-1:0] THRESH_RESET = 16'd20;

  // opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // key codes
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

  // reported mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMERG = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAULT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MAINT = 3'd5;

  // controller state, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_UP    = 6'b000010,
    ST_DOWN  = 6'b000100,
    ST_EMERG = 6'b001000,
    ST_FAULT = 6'b010000,
    ST_MAINT = 6'b100000
  } state_t;

  // one-hot state to reported mode code
  function automatic logic [MODE_W-1:0] state_code(input state_t st);
    logic [MODE_W-1:0] code;
    case (st)
      ST_IDLE:  code = MODE_IDLE;
      ST_UP:    code = MODE_UP;
      ST_DOWN:  code = MODE_DOWN;
      ST_EMERG: code = MODE_EMERG;
      ST_FAULT: code = MODE_FAULT;
      ST_MAINT: code = MODE_MAINT;
      default:  code = MODE_IDLE;
    endcase
    return code;
  endfunction

  // floor number formed by the entry buffer
  function automatic logic [FLOOR_W-1:0] entry_number(input logic [CNT_W-1:0] cnt,
                                                       input logic [KEY_W-1:0] d0,
                                                       input logic [KEY_W-1:0] d1);
    logic [FLOOR_W-1:0] val;
    case (cnt)
      2'd0:    val = '0;
      2'd1:    val = {3'b000, d0};
      default: val = FLOOR_W'({3'b000, d0} * 7'd10) + {3'b000, d1};
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/efc_intf.sv
// item channel interfaces of the elevator floor controller
`default_nettype none

// input item channel
interface efc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [efc_pkg::KEY_W-1:0]       key_code;
  logic                            emergency_button;
  logic [efc_pkg::DIST_W-1:0]      echo_cm;

  modport source (output valid, opcode, key_code, emergency_button, echo_cm,
                  input ready);
  modport sink   (input valid, opcode, key_code, emergency_button, echo_cm,
                  output ready);
endinterface

// result item channel
interface efc_out_if;
  logic                            valid;
  logic                            ready;
  logic [efc_pkg::MODE_W-1:0]      mode;
  logic [efc_pkg::FLOOR_W-1:0]     floor_now;
  logic [efc_pkg::FLOOR_W-1:0]     floor_goal;
  logic                            door_is_open;
  logic                            alarm_on;
  logic                            obstruction_seen;
  logic                            arrived;
  logic [efc_pkg::CNT_W-1:0]       digits_entered;
  logic [efc_pkg::FLOOR_W-1:0]     entry_value;

  modport source (output valid, mode, floor_now, floor_goal, door_is_open, alarm_on,
                         obstruction_seen, arrived, digits_entered, entry_value,
                  input ready);
  modport sink   (input valid, mode, floor_now, floor_goal, door_is_open, alarm_on,
                        obstruction_seen, arrived, digits_entered, entry_value,
                  output ready);
endinterface

// threshold register write channel
interface efc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [efc_pkg::DIST_W-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/elevator_floor_controller.sv
// elevator floor controller: key entry, travel ticks, emergency and maintenance modes
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+-------------
//  in_if    | in  | opcode, key_code, emergency_button, echo_cm      | valid/ready
//  out_if   | out | mode, floors, door, alarm, flags, entry buffer   | valid/ready
//  cfg_if   | in  | obstruction threshold (16 bit)                   | valid/ready
//
// one item per cycle sustained while out_if is not stalled; an accepted item goes into
// the input register, then the mode logic updates state and loads the result register;
// the input register refills while the result waits
// a stalled result holds the input register, in_if.ready drops once both are full
// synchronous active-low reset: idle mode, floor 0, goal 0, empty entry, threshold 20
// cfg_if is always ready; writes are expected only while the block is idle
`default_nettype none

module elevator_floor_controller (
  input  wire          clk,
  input  wire          rst_n,
  efc_in_if.sink       in_if,
  efc_out_if.source    out_if,
  efc_cfg_if.sink      cfg_if
);

  // input register
  logic                            s1_valid_r;
  logic                            s1_opcode_r;
  logic [efc_pkg::KEY_W-1:0]       s1_key_r;
  logic                            s1_button_r;
  logic [efc_pkg::DIST_W-1:0]      s1_dist_r;

  // controller state
  efc_pkg::state_t                 state_r, state_nxt;
  logic [efc_pkg::FLOOR_W-1:0]     floor_r, floor_nxt;
  logic [efc_pkg::FLOOR_W-1:0]     goal_r, goal_nxt;
  logic [efc_pkg::KEY_W-1:0]       digit_r [2];
  logic [efc_pkg::KEY_W-1:0]       digit_nxt [2];
  logic [efc_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            door_r, door_nxt;
  logic                            alarm_r, alarm_nxt;
  logic [efc_pkg::DIST_W-1:0]      thresh_r;

  // result register
  logic                            out_valid_r;
  logic [efc_pkg::MODE_W-1:0]      out_mode_r;
  logic [efc_pkg::FLOOR_W-1:0]     out_floor_r;
  logic [efc_pkg::FLOOR_W-1:0]     out_goal_r;
  logic                            out_door_r;
  logic                            out_alarm_r;
  logic                            out_obst_r;
  logic                            out_arr_r;
  logic [efc_pkg::CNT_W-1:0]       out_count_r;
  logic [efc_pkg::FLOOR_W-1:0]     out_entry_r;

  logic                            s1_go;
  logic                            obst_nxt;
  logic                            arr_nxt;
  logic [efc_pkg::FLOOR_W-1:0]     entry_val;
  logic                            code00;
  logic [efc_pkg::FLOOR_W-1:0]     step_floor;

  // flow control
  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign cfg_if.ready = 1'b1;

  // current entry as a floor number and the maintenance code check
  assign entry_val = efc_pkg::entry_number(count_r, digit_r[0], digit_r[1]);
  assign code00    = (count_r == 2'd2) && (digit_r[0] == '0) && (digit_r[1] == '0);

  // mode logic for the item in the input register
  always_comb begin
    state_nxt    = state_r;
    floor_nxt    = floor_r;
    goal_nxt     = goal_r;
    digit_nxt[0] = digit_r[0];
    digit_nxt[1] = digit_r[1];
    count_nxt    = count_r;
    door_nxt     = door_r;
    alarm_nxt    = alarm_r;
    obst_nxt     = 1'b0;
    arr_nxt      = 1'b0;
    step_floor   = floor_r;
    if (s1_opcode_r == efc_pkg::OP_KEY) begin
      case (state_r)
        efc_pkg::ST_IDLE: begin
          if (s1_key_r <= efc_pkg::KEY_DIGIT_MAX) begin
            // append a digit while the entry has room
            if (count_r < efc_pkg::ENTRY_DIGITS) begin
              digit_nxt[count_r[0]] = s1_key_r;
              count_nxt = count_r + 2'd1;
            end
          end else if (s1_key_r == efc_pkg::KEY_STAR) begin
            // confirm a non-empty entry
            if (count_r != '0) begin
              goal_nxt = entry_val;
              if (code00) begin
                state_nxt = efc_pkg::ST_MAINT;
              end else if (entry_val == floor_r) begin
                state_nxt = efc_pkg::ST_FAULT;
              end else if (entry_val > floor_r) begin
                state_nxt = efc_pkg::ST_UP;
              end else begin
                state_nxt = efc_pkg::ST_DOWN;
              end
              digit_nxt[0] = '0;
              digit_nxt[1] = '0;
              count_nxt    = '0;
            end
          end else if (s1_key_r == efc_pkg::KEY_HASH) begin
            digit_nxt[0] = '0;
            digit_nxt[1] = '0;
            count_nxt    = '0;
          end
        end
        efc_pkg::ST_EMERG: begin
          // star opens the door with alarm, hash closes and leaves emergency
          if (s1_key_r == efc_pkg::KEY_STAR && !door_r) begin
            door_nxt  = 1'b1;
            alarm_nxt = 1'b1;
          end else if (s1_key_r == efc_pkg::KEY_HASH && door_r) begin
            door_nxt  = 1'b0;
            alarm_nxt = 1'b0;
            state_nxt = efc_pkg::ST_IDLE;
          end
        end
        efc_pkg::ST_MAINT: begin
          if (s1_key_r == efc_pkg::KEY_STAR) begin
            state_nxt = efc_pkg::ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (state_r)
        efc_pkg::ST_FAULT: begin
          state_nxt = efc_pkg::ST_IDLE;
        end
        efc_pkg::ST_UP, efc_pkg::ST_DOWN: begin
          // obstruction check comes before the emergency check
          obst_nxt = (s1_dist_r != '0) && (s1_dist_r < thresh_r);
          if (s1_button_r) begin
            state_nxt = efc_pkg::ST_EMERG;
            door_nxt  = 1'b0;
            alarm_nxt = 1'b0;
          end else begin
            // one floor toward the goal
            if (state_r == efc_pkg::ST_UP && floor_r < goal_r) begin
              step_floor = floor_r + 7'd1;
            end else if (state_r == efc_pkg::ST_DOWN && floor_r > goal_r) begin
              step_floor = floor_r - 7'd1;
            end
            floor_nxt = step_floor;
            if (step_floor == goal_r) begin
              arr_nxt   = 1'b1;
              state_nxt = efc_pkg::ST_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_opcode_r <= in_if.opcode;
      s1_key_r    <= in_if.key_code;
      s1_button_r <= in_if.emergency_button;
      s1_dist_r   <= in_if.echo_cm;
    end
  end

  // controller state and threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= efc_pkg::ST_IDLE;
      floor_r    <= '0;
      goal_r     <= '0;
      digit_r[0] <= '0;
      digit_r[1] <= '0;
      count_r    <= '0;
      door_r     <= 1'b0;
      alarm_r    <= 1'b0;
      thresh_r   <= efc_pkg::THRESH_RESET;
    end else begin
      if (s1_go) begin
        state_r    <= state_nxt;
        floor_r    <= floor_nxt;
        goal_r     <= goal_nxt;
        digit_r[0] <= digit_nxt[0];
        digit_r[1] <= digit_nxt[1];
        count_r    <= count_nxt;
        door_r     <= door_nxt;
        alarm_r    <= alarm_nxt;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        thresh_r <= cfg_if.data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_mode_r  <= efc_pkg::state_code(state_nxt);
      out_floor_r <= floor_nxt;
      out_goal_r  <= goal_nxt;
      out_door_r  <= door_nxt;
      out_alarm_r <= alarm_nxt;
      out_obst_r  <= obst_nxt;
      out_arr_r   <= arr_nxt;
      out_count_r <= count_nxt;
      out_entry_r <= efc_pkg::entry_number(count_nxt, digit_nxt[0], digit_nxt[1]);
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.mode             = out_mode_r;
  assign out_if.floor_now        = out_floor_r;
  assign out_if.floor_goal       = out_goal_r;
  assign out_if.door_is_open     = out_door_r;
  assign out_if.alarm_on         = out_alarm_r;
  assign out_if.obstruction_seen = out_obst_r;
  assign out_if.arrived          = out_arr_r;
  assign out_if.digits_entered   = out_count_r;
  assign out_if.entry_value      = out_entry_r;

  // checks
`include "elevator_floor_controller_assert.svh"

  `EFC_ASSERT_IMP(a_arrive_idle, out_valid_r && out_arr_r,
                  (out_mode_r == efc_pkg::MODE_IDLE) && (out_floor_r == out_goal_r))
  `EFC_ASSERT_IMP(a_obst_moving, out_valid_r && out_obst_r,
                  (out_mode_r == efc_pkg::MODE_UP) || (out_mode_r == efc_pkg::MODE_DOWN) ||
                  (out_mode_r == efc_pkg::MODE_EMERG) || (out_mode_r == efc_pkg::MODE_IDLE))
  `EFC_ASSERT_IMP(a_door_emerg, door_r || alarm_r,
                  (state_r == efc_pkg::ST_EMERG) && (door_r == alarm_r))
  `EFC_ASSERT_NXT(a_stall_holds, s1_valid_r && out_valid_r && !out_if.ready,
                  s1_valid_r && $stable(floor_r) && $stable(state_r))

endmodule

`default_nettype wire
